// File: design/assert_macros.svh
// assertion macros shared by the frame driver modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/lmcd_pkg.sv
// shared types, constants and microcode program of the led matrix frame driver
`timescale 1ns / 1ps

package lmcd_pkg;

  localparam int DEVICES         = 4;
  localparam int ROWS_PER_DEVICE = 8;
  localparam int STORE_DEPTH     = DEVICES * ROWS_PER_DEVICE;
  localparam int ADDR_W          = $clog2(STORE_DEPTH);
  localparam int DEV_W           = (DEVICES > 1) ? $clog2(DEVICES) : 1;
  localparam int ROW_W           = $clog2(ROWS_PER_DEVICE);
  localparam int PIX_COLS        = 8 * DEVICES;
  localparam int CFG_FRAMES      = 5;

  localparam logic [7:0] FILL_ON  = 8'hFF;
  localparam logic [7:0] FILL_OFF = 8'h00;
  localparam logic [7:0] MSB_MASK = 8'h80;

  // chip register addresses
  localparam logic [3:0] REG_NOOP      = 4'h0;
  localparam logic [3:0] REG_DECODE    = 4'h9;
  localparam logic [3:0] REG_INTENSITY = 4'hA;
  localparam logic [3:0] REG_SCAN      = 4'hB;
  localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
  localparam logic [3:0] REG_TEST      = 4'hF;

  typedef enum logic [1:0] {
    CMD_SETPIX  = 2'd0,
    CMD_CLEAR   = 2'd1,
    CMD_REFRESH = 2'd2,
    CMD_CONFIG  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    COL_WHITE   = 2'd0,
    COL_BLACK   = 2'd1,
    COL_INVERSE = 2'd2,
    COL_BAD     = 2'd3
  } colour_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_ERR   = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    CFG_LAYOUT    = 3'd0,
    CFG_DECODE    = 3'd1,
    CFG_INTENSITY = 3'd2,
    CFG_SCAN      = 3'd3,
    CFG_NORMAL    = 3'd4,
    CFG_TEST      = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic       layout;
    logic [7:0] decode;
    logic [3:0] intensity;
    logic [2:0] scan_limit;
    logic       normal;
    logic       test;
  } cfg_t;

  typedef struct packed {
    logic err;
    logic scan_more;
    logic cfg_more;
  } flags_t;

  // microcode fields
  typedef enum logic [1:0] {EM_NONE, EM_STATUS, EM_SCAN, EM_CFG} emit_e;
  typedef enum logic [1:0] {RD_NONE, RD_PIX, RD_CUR, RD_NXT} rd_e;
  typedef enum logic [1:0] {WR_NONE, WR_PIX, WR_FILL, WR_ZERO} wr_e;
  typedef enum logic [1:0] {C_NEVER, C_ERR, C_SCAN_MORE, C_CFG_MORE} cond_e;

  typedef logic [3:0] upc_t;

  typedef struct packed {
    emit_e emit;
    rd_e   rd;
    wr_e   wr;
    logic  adv;
    cond_e cond;
    upc_t  target;
    logic  done;
  } uword_t;

  // program entry points and steps
  localparam upc_t UA_SP0  = 4'd0;
  localparam upc_t UA_SP1  = 4'd1;
  localparam upc_t UA_ERR  = 4'd2;
  localparam upc_t UA_CL0  = 4'd3;
  localparam upc_t UA_CL1  = 4'd4;
  localparam upc_t UA_CL2  = 4'd5;
  localparam upc_t UA_RF0  = 4'd6;
  localparam upc_t UA_RF1  = 4'd7;
  localparam upc_t UA_CF0  = 4'd8;
  localparam upc_t UA_CF1  = 4'd9;
  localparam upc_t UA_INIT = 4'd10;

  localparam uword_t UW_NOP = '{emit: EM_NONE, rd: RD_NONE, wr: WR_NONE, adv: 1'b0,
                                cond: C_NEVER, target: UA_SP0, done: 1'b1};

  function automatic uword_t ucode_rom(input upc_t pc);
    uword_t w;
    w = UW_NOP;
    case (pc)
      UA_SP0: w = '{emit: EM_NONE, rd: RD_PIX, wr: WR_NONE, adv: 1'b0,
                    cond: C_ERR, target: UA_ERR, done: 1'b0};
      UA_SP1: w = '{emit: EM_STATUS, rd: RD_NONE, wr: WR_PIX, adv: 1'b0,
                    cond: C_NEVER, target: UA_SP0, done: 1'b1};
      UA_ERR: w = '{emit: EM_STATUS, rd: RD_NONE, wr: WR_NONE, adv: 1'b0,
                    cond: C_NEVER, target: UA_SP0, done: 1'b1};
      UA_CL0: w = '{emit: EM_NONE, rd: RD_NONE, wr: WR_NONE, adv: 1'b0,
                    cond: C_ERR, target: UA_ERR, done: 1'b0};
      UA_CL1: w = '{emit: EM_NONE, rd: RD_NONE, wr: WR_FILL, adv: 1'b1,
                    cond: C_SCAN_MORE, target: UA_CL1, done: 1'b0};
      UA_CL2: w = '{emit: EM_STATUS, rd: RD_NONE, wr: WR_NONE, adv: 1'b0,
                    cond: C_NEVER, target: UA_SP0, done: 1'b1};
      UA_RF0: w = '{emit: EM_NONE, rd: RD_CUR, wr: WR_NONE, adv: 1'b0,
                    cond: C_NEVER, target: UA_SP0, done: 1'b0};
      UA_RF1: w = '{emit: EM_SCAN, rd: RD_NXT, wr: WR_NONE, adv: 1'b1,
                    cond: C_SCAN_MORE, target: UA_RF1, done: 1'b1};
      UA_CF0: w = '{emit: EM_NONE, rd: RD_NONE, wr: WR_NONE, adv: 1'b0,
                    cond: C_ERR, target: UA_ERR, done: 1'b0};
      UA_CF1: w = '{emit: EM_CFG, rd: RD_NONE, wr: WR_NONE, adv: 1'b1,
                    cond: C_CFG_MORE, target: UA_CF1, done: 1'b1};
      UA_INIT: w = '{emit: EM_NONE, rd: RD_NONE, wr: WR_ZERO, adv: 1'b1,
                     cond: C_SCAN_MORE, target: UA_INIT, done: 1'b1};
      default: w = UW_NOP;
    endcase
    return w;
  endfunction

endpackage

// File: design/led_matrix_chain_framebuffer_driver_top.sv
// top level: configuration registers, microcode sequencer and datapath
// set pixel: reads the store word while checking the command, then writes the updated word and reports its status
// clear: 8*DEVICES store writes, one per cycle
// refresh: one store read per cycle, 8*DEVICES words in consecutive cycles
// configure: 5*DEVICES words in consecutive cycles; a rejected command ends in a status word only
// reset sets register defaults and clears all 8*DEVICES store words with busy high
`timescale 1ns / 1ps

module led_matrix_chain_framebuffer_driver_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        in_command,
  input  logic signed [7:0] in_pixel_x,
  input  logic signed [7:0] in_pixel_y,
  input  logic [1:0]        in_colour,
  input  logic [3:0]        in_device_index,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [7:0]        cfg_wdata,
  output logic              out_valid,
  output logic              out_word_valid,
  output logic [3:0]        out_chip_register,
  output logic [7:0]        out_chip_data,
  output logic              out_frame_end,
  output logic [1:0]        out_status,
  output logic              out_last_result
);

  import lmcd_pkg::*;

  cfg_t   cfg_r, cfg_nxt;
  flags_t flags;
  uword_t uw;
  logic   accept;
  logic   seq_busy;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx_e'(cfg_index))
        CFG_LAYOUT:    cfg_nxt.layout     = cfg_wdata[0];
        CFG_DECODE:    cfg_nxt.decode     = cfg_wdata;
        CFG_INTENSITY: cfg_nxt.intensity  = cfg_wdata[3:0];
        CFG_SCAN:      cfg_nxt.scan_limit = cfg_wdata[2:0];
        CFG_NORMAL:    cfg_nxt.normal     = cfg_wdata[0];
        CFG_TEST:      cfg_nxt.test       = cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{layout: 1'b0, decode: 8'd0, intensity: 4'd1, scan_limit: 3'd7,
                 normal: 1'b1, test: 1'b0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lmcd_useq u_useq (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .cmd    (cmd_e'(in_command)),
    .flags  (flags),
    .busy   (seq_busy),
    .accept (accept),
    .uw     (uw)
  );

  lmcd_dpath u_dpath (
    .clk               (clk),
    .rst_n             (rst_n),
    .accept            (accept),
    .busy              (seq_busy),
    .uw                (uw),
    .cfg               (cfg_r),
    .in_command        (in_command),
    .in_pixel_x        (in_pixel_x),
    .in_pixel_y        (in_pixel_y),
    .in_colour         (in_colour),
    .in_device_index   (in_device_index),
    .flags             (flags),
    .out_valid         (out_valid),
    .out_word_valid    (out_word_valid),
    .out_chip_register (out_chip_register),
    .out_chip_data     (out_chip_data),
    .out_frame_end     (out_frame_end),
    .out_status        (out_status),
    .out_last_result   (out_last_result)
  );

  assign busy = seq_busy;

endmodule

// File: design/lmcd_ram.sv
// generic single write port ram with registered read
`timescale 1ns / 1ps

module lmcd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: design/lmcd_useq.sv
// microcode sequencer: step counter, control rom and conditional jumps
`timescale 1ns / 1ps

module lmcd_useq (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lmcd_pkg::cmd_e    cmd,
  input  lmcd_pkg::flags_t  flags,
  output logic              busy,
  output logic              accept,
  output lmcd_pkg::uword_t  uw
);

  import lmcd_pkg::*;

  upc_t   pc_r, pc_nxt;
  logic   busy_r, busy_nxt;
  uword_t rom_w;
  logic   jump;
  upc_t   entry;

  assign rom_w  = ucode_rom(pc_r);
  assign accept = start && !busy_r;

  always_comb begin
    case (rom_w.cond)
      C_NEVER:     jump = 1'b0;
      C_ERR:       jump = flags.err;
      C_SCAN_MORE: jump = flags.scan_more;
      C_CFG_MORE:  jump = flags.cfg_more;
      default:     jump = 1'b0;
    endcase
  end

  always_comb begin
    case (cmd)
      CMD_SETPIX:  entry = UA_SP0;
      CMD_CLEAR:   entry = UA_CL0;
      CMD_REFRESH: entry = UA_RF0;
      CMD_CONFIG:  entry = UA_CF0;
      default:     entry = UA_CF0;
    endcase
  end

  always_comb begin
    pc_nxt   = pc_r;
    busy_nxt = busy_r;
    if (accept) begin
      pc_nxt   = entry;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (jump) begin
        pc_nxt = rom_w.target;
      end else if (rom_w.done) begin
        busy_nxt = 1'b0;
      end else begin
        pc_nxt = pc_r + upc_t'(1);
      end
    end
  end

  // reset starts the store clearing program
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r   <= UA_INIT;
      busy_r <= 1'b1;
    end else begin
      pc_r   <= pc_nxt;
      busy_r <= busy_nxt;
    end
  end

  assign busy = busy_r;
  assign uw   = busy_r ? rom_w : UW_NOP;

`include "assert_macros.svh"

  `ASSERT_NEXT(a_accept_busy, accept, busy_r, "accepted command did not raise busy")
  `ASSERT_NEXT(a_done_idle, busy_r && rom_w.done && !jump, !busy_r,
               "finished program kept busy high")

endmodule

// File: design/lmcd_dpath.sv
// datapath: command latch, scan counters, frame store and result register
`timescale 1ns / 1ps

module lmcd_dpath (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic               busy,
  input  lmcd_pkg::uword_t   uw,
  input  lmcd_pkg::cfg_t     cfg,
  input  logic [1:0]         in_command,
  input  logic signed [7:0]  in_pixel_x,
  input  logic signed [7:0]  in_pixel_y,
  input  logic [1:0]         in_colour,
  input  logic [3:0]         in_device_index,
  output lmcd_pkg::flags_t   flags,
  output logic               out_valid,
  output logic               out_word_valid,
  output logic [3:0]         out_chip_register,
  output logic [7:0]         out_chip_data,
  output logic               out_frame_end,
  output logic [1:0]         out_status,
  output logic               out_last_result
);

  import lmcd_pkg::*;

  localparam logic [DEV_W-1:0] DEV_MAX    = DEV_W'(DEVICES - 1);
  localparam logic [ROW_W-1:0] LAST_ROW   = ROW_W'(ROWS_PER_DEVICE - 1);
  localparam logic [ROW_W-1:0] LAST_FRAME = ROW_W'(CFG_FRAMES - 1);
  localparam logic [3:0]       DEV_LIMIT  = 4'(DEVICES);

  function automatic logic [ADDR_W-1:0] addr_of(input logic [ROW_W-1:0] row,
                                                input logic [ADDR_W-1:0] slot);
    return ADDR_W'(row) * ADDR_W'(DEVICES) + slot;
  endfunction

  // latched command beat
  cmd_e             cmd_r;
  logic signed [7:0] x_r, y_r;
  colour_e          colour_r;
  logic [3:0]       dev_idx_r;

  logic [ROW_W-1:0] row_r, row_nxt, row_adv;
  logic [DEV_W-1:0] dev_r, dev_nxt, dev_adv;

  logic              pix_oob, colour_bad, clear_bad, dev_bad;
  logic              err_flag, scan_more, cfg_more;
  status_e           status_val;
  logic [ROW_W-1:0]  pix_row;
  logic [ADDR_W-1:0] pix_addr, cur_addr, nxt_addr;
  logic [7:0]        mask, pix_new;

  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [7:0]        ram_wdata, ram_rdata;

  logic       hit;
  logic [3:0] cfg_reg;
  logic [7:0] cfg_val;

  logic       out_valid_r, out_word_valid_r, out_frame_end_r, out_last_r;
  logic [3:0] out_reg_r;
  logic [7:0] out_data_r;
  status_e    out_status_r;

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r     <= cmd_e'(in_command);
      x_r       <= in_pixel_x;
      y_r       <= in_pixel_y;
      colour_r  <= colour_e'(in_colour);
      dev_idx_r <= in_device_index;
    end
  end

  // checks
  assign pix_oob = x_r[7] || ($unsigned(x_r) >= 8'(PIX_COLS)) ||
                   y_r[7] || ($unsigned(y_r) >= 8'(ROWS_PER_DEVICE));
  assign colour_bad = (colour_r == COL_BAD);
  assign clear_bad  = (colour_r == COL_INVERSE) || (colour_r == COL_BAD);
  assign dev_bad    = (dev_idx_r >= DEV_LIMIT);

  always_comb begin
    case (cmd_r)
      CMD_SETPIX: begin
        err_flag   = pix_oob || colour_bad;
        status_val = pix_oob ? ST_RANGE : (colour_bad ? ST_ERR : ST_OK);
      end
      CMD_CLEAR: begin
        err_flag   = clear_bad;
        status_val = clear_bad ? ST_ERR : ST_OK;
      end
      CMD_CONFIG: begin
        err_flag   = dev_bad;
        status_val = dev_bad ? ST_ERR : ST_OK;
      end
      default: begin
        err_flag   = 1'b0;
        status_val = ST_OK;
      end
    endcase
  end

  // scan counters: row ascending, device descending
  always_comb begin
    if (dev_r == '0) begin
      dev_adv = DEV_MAX;
      row_adv = row_r + ROW_W'(1);
    end else begin
      dev_adv = dev_r - DEV_W'(1);
      row_adv = row_r;
    end
  end

  always_comb begin
    row_nxt = row_r;
    dev_nxt = dev_r;
    if (!busy) begin
      row_nxt = '0;
      dev_nxt = DEV_MAX;
    end else if (uw.adv) begin
      row_nxt = row_adv;
      dev_nxt = dev_adv;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= '0;
      dev_r <= DEV_MAX;
    end else begin
      row_r <= row_nxt;
      dev_r <= dev_nxt;
    end
  end

  assign scan_more = !((row_r == LAST_ROW) && (dev_r == '0));
  assign cfg_more  = !((row_r == LAST_FRAME) && (dev_r == '0));
  assign flags     = '{err: err_flag, scan_more: scan_more, cfg_more: cfg_more};

  // pixel addressing
  assign pix_row  = cfg.layout ? ~y_r[ROW_W-1:0] : y_r[ROW_W-1:0];
  assign pix_addr = addr_of(pix_row, ADDR_W'(x_r[7:3]));
  assign cur_addr = addr_of(row_r, ADDR_W'(dev_r));
  assign nxt_addr = addr_of(row_adv, ADDR_W'(dev_adv));
  assign mask     = cfg.layout ? (8'h01 << x_r[2:0]) : (MSB_MASK >> x_r[2:0]);

  always_comb begin
    case (colour_r)
      COL_WHITE: pix_new = ram_rdata | mask;
      COL_BLACK: pix_new = ram_rdata & ~mask;
      default:   pix_new = ram_rdata ^ mask;
    endcase
  end

  always_comb begin
    case (uw.rd)
      RD_PIX:  ram_raddr = pix_addr;
      RD_NXT:  ram_raddr = nxt_addr;
      default: ram_raddr = cur_addr;
    endcase
  end

  always_comb begin
    case (uw.wr)
      WR_PIX:  ram_wdata = pix_new;
      WR_FILL: ram_wdata = (colour_r == COL_WHITE) ? FILL_ON : FILL_OFF;
      default: ram_wdata = FILL_OFF;
    endcase
  end

  assign ram_we    = (uw.wr != WR_NONE);
  assign ram_waddr = (uw.wr == WR_PIX) ? pix_addr : cur_addr;

  lmcd_ram #(
    .WIDTH (8),
    .DEPTH (STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // configure frames, indexed by the frame counter
  assign hit = (4'(dev_r) == dev_idx_r);

  always_comb begin
    case (row_r)
      3'd0: begin
        cfg_reg = REG_DECODE;
        cfg_val = cfg.decode;
      end
      3'd1: begin
        cfg_reg = REG_INTENSITY;
        cfg_val = 8'(cfg.intensity);
      end
      3'd2: begin
        cfg_reg = REG_SCAN;
        cfg_val = 8'(cfg.scan_limit);
      end
      3'd3: begin
        cfg_reg = REG_TEST;
        cfg_val = 8'(cfg.test);
      end
      default: begin
        cfg_reg = REG_SHUTDOWN;
        cfg_val = 8'(cfg.normal);
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (uw.emit != EM_NONE);
    end
  end

  always_ff @(posedge clk) begin
    case (uw.emit)
      EM_STATUS: begin
        out_word_valid_r <= 1'b0;
        out_reg_r        <= REG_NOOP;
        out_data_r       <= FILL_OFF;
        out_frame_end_r  <= 1'b0;
        out_status_r     <= status_val;
        out_last_r       <= 1'b1;
      end
      EM_SCAN: begin
        out_word_valid_r <= 1'b1;
        out_reg_r        <= 4'(row_r) + 4'd1;
        out_data_r       <= ram_rdata;
        out_frame_end_r  <= (dev_r == '0);
        out_status_r     <= ST_OK;
        out_last_r       <= !scan_more;
      end
      EM_CFG: begin
        out_word_valid_r <= 1'b1;
        out_reg_r        <= hit ? cfg_reg : REG_NOOP;
        out_data_r       <= hit ? cfg_val : FILL_OFF;
        out_frame_end_r  <= (dev_r == '0);
        out_status_r     <= ST_OK;
        out_last_r       <= !cfg_more;
      end
      default: begin
      end
    endcase
  end

  assign out_valid         = out_valid_r;
  assign out_word_valid    = out_word_valid_r;
  assign out_chip_register = out_reg_r;
  assign out_chip_data     = out_data_r;
  assign out_frame_end     = out_frame_end_r;
  assign out_status        = out_status_r;
  assign out_last_result   = out_last_r;

`include "assert_macros.svh"

  `ASSERT_IMPL(a_no_idle_write, !busy, !ram_we, "frame store written while idle")
  `ASSERT_IMPL(a_word_ok, out_valid_r && out_word_valid_r, out_status_r == ST_OK,
               "chain word carries a non-ok status")

endmodule

// File: sim/tb_led_matrix_chain_framebuffer_driver_top.sv
// self-checking testbench for the led matrix chain frame driver top level
`timescale 1ns / 1ps

module tb_led_matrix_chain_framebuffer_driver_top;
  import lmcd_pkg::*;

  localparam logic [2:0] CFG_SPARE_LO = 3'd6;
  localparam logic [2:0] CFG_SPARE_HI = 3'd7;
  localparam int PHASES = 7;
  localparam int PHASE_ITEMS = 50;

  class chain_word_scoreboard;
    typedef struct {
      logic       word_valid;
      logic [3:0] chip_reg;
      logic [7:0] data;
      logic       frame_end;
      logic [1:0] status;
      logic       last;
    } chain_word_t;

    logic [7:0]  pixel_shadow [STORE_DEPTH];
    cfg_t        regs;
    chain_word_t expected_words [$];
    int          errors;

    function new();
      foreach (pixel_shadow[i]) pixel_shadow[i] = FILL_OFF;
      regs = '{layout: 1'b0, decode: 8'h00, intensity: 4'd1, scan_limit: 3'd7,
               normal: 1'b1, test: 1'b0};
      errors = 0;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function void write_reg(logic [2:0] idx, logic [7:0] value);
      case (idx)
        CFG_LAYOUT:    regs.layout = value[0];
        CFG_DECODE:    regs.decode = value;
        CFG_INTENSITY: regs.intensity = value[3:0];
        CFG_SCAN:      regs.scan_limit = value[2:0];
        CFG_NORMAL:    regs.normal = value[0];
        CFG_TEST:      regs.test = value[0];
        default: ;
      endcase
    endfunction

    function void push_word(logic wv, logic [3:0] r, logic [7:0] d, logic fe,
                            logic [1:0] st, logic lst);
      chain_word_t w;
      w = '{wv, r, d, fe, st, lst};
      expected_words.push_back(w);
    endfunction

    function void note_command(logic [1:0] cmd, logic signed [7:0] x,
                               logic signed [7:0] y, logic [1:0] colour,
                               logic [3:0] dev);
      int col, row, addr;
      logic [7:0] bitmask, fill;
      logic [3:0] cfg_reg [CFG_FRAMES];
      logic [7:0] cfg_val [CFG_FRAMES];
      logic [1:0] st;
      st = ST_OK;
      case (cmd)
        CMD_SETPIX: begin
          col = int'(x);
          row = int'(y);
          if (col < 0 || col >= PIX_COLS || row < 0 || row >= ROWS_PER_DEVICE) begin
            st = ST_RANGE;
          end else if (colour == COL_BAD) begin
            st = ST_ERR;
          end else begin
            // flipped layout: rows mirrored, leftmost pixel in the lsb
            if (regs.layout) begin
              row = ROWS_PER_DEVICE - 1 - row;
              bitmask = 8'h01 << (col % 8);
            end else begin
              bitmask = MSB_MASK >> (col % 8);
            end
            addr = col / 8 + row * DEVICES;
            case (colour)
              COL_WHITE: pixel_shadow[addr] |= bitmask;
              COL_BLACK: pixel_shadow[addr] &= ~bitmask;
              default:   pixel_shadow[addr] ^= bitmask;
            endcase
          end
          push_word(1'b0, REG_NOOP, 8'h00, 1'b0, st, 1'b1);
        end
        CMD_CLEAR: begin
          if (colour == COL_WHITE || colour == COL_BLACK) begin
            fill = (colour == COL_WHITE) ? FILL_ON : FILL_OFF;
            foreach (pixel_shadow[i]) pixel_shadow[i] = fill;
          end else begin
            st = ST_ERR;
          end
          push_word(1'b0, REG_NOOP, 8'h00, 1'b0, st, 1'b1);
        end
        CMD_REFRESH: begin
          // farthest device first in every frame
          for (int r = 0; r < ROWS_PER_DEVICE; r++)
            for (int d = DEVICES - 1; d >= 0; d--)
              push_word(1'b1, 4'(r + 1), pixel_shadow[d + r * DEVICES], d == 0, ST_OK,
                        r == ROWS_PER_DEVICE - 1 && d == 0);
        end
        default: begin
          if (dev >= DEVICES) begin
            push_word(1'b0, REG_NOOP, 8'h00, 1'b0, ST_ERR, 1'b1);
          end else begin
            cfg_reg = '{REG_DECODE, REG_INTENSITY, REG_SCAN, REG_TEST, REG_SHUTDOWN};
            cfg_val = '{regs.decode, 8'(regs.intensity), 8'(regs.scan_limit),
                        8'(regs.test), 8'(regs.normal)};
            for (int f = 0; f < CFG_FRAMES; f++)
              for (int d = DEVICES - 1; d >= 0; d--)
                push_word(1'b1, d == dev ? cfg_reg[f] : REG_NOOP,
                          d == dev ? cfg_val[f] : 8'h00, d == 0, ST_OK,
                          f == CFG_FRAMES - 1 && d == 0);
          end
        end
      endcase
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_word(logic wv, logic [3:0] r, logic [7:0] d, logic fe,
                             logic [1:0] st, logic lst);
      chain_word_t w;
      if (expected_words.size() == 0) begin
        $error("result beat with nothing expected: register %0h data %0h", r, d);
        errors++;
        return;
      end
      w = expected_words.pop_front();
      compare("word_valid", 8'(w.word_valid), 8'(wv));
      compare("chip_register", 8'(w.chip_reg), 8'(r));
      compare("chip_data", w.data, d);
      compare("frame_end", 8'(w.frame_end), 8'(fe));
      compare("status", 8'(w.status), 8'(st));
      compare("last_result", 8'(w.last), 8'(lst));
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_command;
  logic signed [7:0] in_pixel_x;
  logic signed [7:0] in_pixel_y;
  logic [1:0]        in_colour;
  logic [3:0]        in_device_index;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [7:0]        cfg_wdata;
  logic              out_valid;
  logic              out_word_valid;
  logic [3:0]        out_chip_register;
  logic [7:0]        out_chip_data;
  logic              out_frame_end;
  logic [1:0]        out_status;
  logic              out_last_result;

  chain_word_scoreboard sb = new();

  led_matrix_chain_framebuffer_driver_top dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_pixel_x        (in_pixel_x),
    .in_pixel_y        (in_pixel_y),
    .in_colour         (in_colour),
    .in_device_index   (in_device_index),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .out_valid         (out_valid),
    .out_word_valid    (out_word_valid),
    .out_chip_register (out_chip_register),
    .out_chip_data     (out_chip_data),
    .out_frame_end     (out_frame_end),
    .out_status        (out_status),
    .out_last_result   (out_last_result)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_word(out_word_valid, out_chip_register, out_chip_data, out_frame_end,
                    out_status, out_last_result);
  end

  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 19);
    if (quiet || r < 10) return 0;
    if (r < 17) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pad(logic [7:0] v, int w);
    return (8'($urandom) << w) | v;
  endfunction

  task automatic issue(input logic [1:0] cmd, input logic signed [7:0] x,
                       input logic signed [7:0] y, input logic [1:0] col,
                       input logic [3:0] dev, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_command <= cmd;
    in_pixel_x <= x;
    in_pixel_y <= y;
    in_colour <= col;
    in_device_index <= dev;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    sb.note_command(cmd, x, y, col, dev);
  endtask

  task automatic wait_idle();
    int guard;
    start <= 1'b0;
    guard = 0;
    while (sb.pending() != 0 && guard < 20000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic program_regs(input logic lay, input logic [7:0] dec,
                              input logic [3:0] inten, input logic [2:0] scan,
                              input logic norm, input logic tst, input bit spare);
    logic [2:0] idx [8];
    logic [7:0] val [8];
    idx = '{CFG_LAYOUT, CFG_DECODE, CFG_INTENSITY, CFG_SCAN, CFG_NORMAL, CFG_TEST,
            CFG_SPARE_LO, CFG_SPARE_HI};
    val = '{pad(8'(lay), 1), dec, pad(8'(inten), 4), pad(8'(scan), 3),
            pad(8'(norm), 1), pad(8'(tst), 1), 8'($urandom), 8'($urandom)};
    for (int n = 0; n < (spare ? 8 : 6); n++) begin
      cfg_we <= 1'b1;
      cfg_index <= idx[n];
      cfg_wdata <= val[n];
      @(posedge clk);
      sb.write_reg(idx[n], val[n]);
    end
    cfg_we <= 1'b0;
  endtask

  task automatic random_item(input bit quiet);
    logic [1:0] cmd, col;
    logic signed [7:0] x, y;
    logic [3:0] dev;
    int pick;
    pick = $urandom_range(0, 99);
    cmd = pick < 55 ? CMD_SETPIX : pick < 65 ? CMD_CLEAR : pick < 85 ? CMD_REFRESH
                                                                     : CMD_CONFIG;
    x = 8'($urandom_range(0, PIX_COLS - 1));
    y = 8'($urandom_range(0, ROWS_PER_DEVICE - 1));
    case ($urandom_range(0, 9))
      0: begin
        x = 8'($urandom);
        y = 8'($urandom);
      end
      1: x = $urandom_range(0, 1) ? 8'hFF : 8'(PIX_COLS);
      2: y = $urandom_range(0, 1) ? 8'hFF : 8'(ROWS_PER_DEVICE);
      default: ;
    endcase
    if (cmd == CMD_CLEAR)
      col = $urandom_range(0, 7) ? 2'($urandom_range(COL_WHITE, COL_BLACK))
                                 : 2'($urandom_range(COL_INVERSE, COL_BAD));
    else
      col = $urandom_range(0, 9) ? 2'($urandom_range(COL_WHITE, COL_INVERSE)) : COL_BAD;
    dev = $urandom_range(0, 4) ? 4'($urandom_range(0, DEVICES - 1)) : 4'($urandom);
    issue(cmd, x, y, col, dev, pick_gap(quiet));
  endtask

  initial begin
    rst_n <= 1'b0;
    start <= 1'b0;
    in_command <= CMD_SETPIX;
    in_pixel_x <= 8'h00;
    in_pixel_y <= 8'h00;
    in_colour <= COL_WHITE;
    in_device_index <= 4'h0;
    cfg_we <= 1'b0;
    cfg_index <= CFG_LAYOUT;
    cfg_wdata <= 8'h00;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    wait_idle();

    issue(CMD_REFRESH, 8'h00, 8'h00, COL_WHITE, 4'h0, pick_gap(1'b0));
    issue(CMD_SETPIX, 8'h00, 8'h00, COL_WHITE, 4'h0, pick_gap(1'b0));
    issue(CMD_SETPIX, 8'd31, 8'd7, COL_WHITE, 4'h0, pick_gap(1'b0));
    issue(CMD_SETPIX, 8'd31, 8'd0, COL_INVERSE, 4'h0, pick_gap(1'b0));
    issue(CMD_SETPIX, 8'd8, 8'd3, COL_WHITE, 4'h0, pick_gap(1'b0));
    issue(CMD_SETPIX, 8'd8, 8'd3, COL_BLACK, 4'h0, pick_gap(1'b0));
    issue(CMD_SETPIX, 8'hFF, 8'd0, COL_WHITE, 4'h0, pick_gap(1'b0));
    issue(CMD_SETPIX, 8'(PIX_COLS), 8'd0, COL_WHITE, 4'h0, pick_gap(1'b0));
    issue(CMD_SETPIX, 8'd0, 8'(ROWS_PER_DEVICE), COL_BLACK, 4'h0, pick_gap(1'b0));
    issue(CMD_SETPIX, 8'h80, 8'h7F, COL_WHITE, 4'h0, pick_gap(1'b0));
    issue(CMD_SETPIX, 8'h7F, 8'hFF, COL_INVERSE, 4'h0, pick_gap(1'b0));
    issue(CMD_SETPIX, 8'd5, 8'd5, COL_BAD, 4'h0, pick_gap(1'b0));
    // bad colour on a bad coordinate reports the coordinate
    issue(CMD_SETPIX, 8'd40, 8'd2, COL_BAD, 4'h0, pick_gap(1'b0));
    issue(CMD_REFRESH, 8'h00, 8'h00, COL_WHITE, 4'h0, pick_gap(1'b0));
    issue(CMD_CONFIG, 8'h00, 8'h00, COL_WHITE, 4'h0, pick_gap(1'b0));
    issue(CMD_CONFIG, 8'h00, 8'h00, COL_WHITE, 4'(DEVICES - 1), pick_gap(1'b0));
    issue(CMD_CONFIG, 8'h00, 8'h00, COL_WHITE, 4'(DEVICES), pick_gap(1'b0));
    issue(CMD_CONFIG, 8'h00, 8'h00, COL_WHITE, 4'hF, pick_gap(1'b0));
    issue(CMD_CLEAR, 8'h00, 8'h00, COL_INVERSE, 4'h0, pick_gap(1'b0));
    issue(CMD_CLEAR, 8'h00, 8'h00, COL_BAD, 4'h0, pick_gap(1'b0));
    issue(CMD_REFRESH, 8'h00, 8'h00, COL_WHITE, 4'h0, pick_gap(1'b0));
    issue(CMD_CLEAR, 8'h00, 8'h00, COL_WHITE, 4'h0, pick_gap(1'b0));
    issue(CMD_SETPIX, 8'd15, 8'd4, COL_INVERSE, 4'h0, pick_gap(1'b0));
    issue(CMD_REFRESH, 8'h00, 8'h00, COL_WHITE, 4'h0, pick_gap(1'b0));
    issue(CMD_CLEAR, 8'h00, 8'h00, COL_BLACK, 4'h0, pick_gap(1'b0));

    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      case (p)
        0: program_regs(1'b0, 8'h00, 4'h0, 3'h0, 1'b0, 1'b0, 1'b1);
        1: program_regs(1'b1, 8'hFF, 4'hF, 3'h7, 1'b1, 1'b1, 1'b0);
        default: program_regs(1'($urandom), 8'($urandom), 4'($urandom), 3'($urandom),
                              1'($urandom), 1'($urandom), p[0]);
      endcase
      for (int k = 0; k < PHASE_ITEMS; k++) random_item(p == 2 || p == 5);
    end

    wait_idle();
    if (sb.pending() != 0) begin
      $error("%0d expected result beats never arrived", sb.pending());
      sb.errors++;
    end
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
